[design/icosphere_triangle_subdivider_defines.svh]
// Assertion macros used by the port-level checker of the icosphere subdivider.
// No dependencies.
`ifndef ICOSPHERE_TRIANGLE_SUBDIVIDER_DEFINES_SVH
`define ICOSPHERE_TRIANGLE_SUBDIVIDER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define ICO_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ICO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/ico_pkg.sv]
// Shared types and constants of the icosphere triangle subdivider.
// No dependencies.
package ico_pkg;

    localparam int LEVEL_WIDTH = 2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the input triangle onto the stack
        logic pop;         // read the top of stack into the work registers
        logic norm_start;  // start normalizing the three midpoints
        logic push_children;
        logic emit;        // move the work triangle to the output register
    } ico_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic norm_done;
        logic need_split;  // work triangle level below target
        logic stack_empty;
        logic out_busy;    // output register still holds a result
    } ico_stat_t;

endpackage

[design/ico_norm.sv]
// Normalizes one doubled midpoint vector onto the unit sphere.
// Per-axis bisection of the rounded quotient; no package dependencies.
module ico_norm #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_WIDTH-1:0] p [3],
    input  logic signed [COORD_WIDTH-1:0] r [3],
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] o [3]
);
    localparam int FB = COORD_WIDTH - 2;
    localparam int CF = (FB < 14) ? FB : 14;
    localparam int PS = (COORD_WIDTH > 16) ? COORD_WIDTH - 16 : 0;
    localparam int MW = COORD_WIDTH + 1 - PS;  // magnitude width
    localparam int SW = 2 * MW + 2;            // sum width
    localparam int QW = CF + 1;
    localparam int TW = QW + 1;
    localparam int PW = 2 * TW + SW;

    logic [MW-1:0]  mag_reg [3];
    logic [2:0]     neg_reg;
    logic [SW-1:0]  sum_reg;
    logic [QW-1:0]  lo_reg, hi_reg;
    logic [1:0]     axis_reg;
    logic [2:0]     phase_reg;  // 0 idle, 1 sum, 2 search, 3 square, 4 mul, 5 compare
    logic [TW-1:0]  t_reg;
    logic [2*TW-1:0] tt_reg;
    logic [PW-1:0]  prod_reg;
    logic signed [COORD_WIDTH-1:0] o_reg [3];

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SUM  = 3'd1;
    localparam logic [2:0] PH_MID  = 3'd2;
    localparam logic [2:0] PH_SQ   = 3'd3;
    localparam logic [2:0] PH_MUL  = 3'd4;
    localparam logic [2:0] PH_CMP  = 3'd5;

    logic [QW-1:0] mid;
    logic [PW-1:0] rhs;
    logic [MW-1:0] cur_mag;

    always_comb
    begin
        mid     = QW'((({1'b0, lo_reg} + {1'b0, hi_reg} + (QW+1)'(1)) >> 1));
        cur_mag = mag_reg[axis_reg];
        rhs     = (PW'(cur_mag) * PW'(cur_mag)) << (2 * CF + 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            logic signed [COORD_WIDTH:0] s;
                            logic [COORD_WIDTH:0] a;
                            s = (COORD_WIDTH+1)'(p[k]) + (COORD_WIDTH+1)'(r[k]);
                            a = s[COORD_WIDTH] ? (COORD_WIDTH+1)'(-s) : (COORD_WIDTH+1)'(s);
                            neg_reg[k] <= s[COORD_WIDTH];
                            mag_reg[k] <= MW'(a >> PS);
                        end
                        phase_reg <= PH_SUM;
                    end
                end
                PH_SUM:
                begin
                    sum_reg <= SW'(mag_reg[0]) * SW'(mag_reg[0])
                             + SW'(mag_reg[1]) * SW'(mag_reg[1])
                             + SW'(mag_reg[2]) * SW'(mag_reg[2]);
                    axis_reg  <= 2'd0;
                    lo_reg    <= '0;
                    hi_reg    <= QW'(1) << CF;
                    phase_reg <= PH_MID;
                end
                PH_MID:
                begin
                    if (sum_reg == '0 || lo_reg >= hi_reg)
                    begin
                        logic [COORD_WIDTH-1:0] q;
                        q = COORD_WIDTH'(lo_reg) << (FB - CF);
                        if (sum_reg == '0)
                            o_reg[axis_reg] <= '0;
                        else
                            o_reg[axis_reg] <= neg_reg[axis_reg] ? -q : q;
                        if (axis_reg == 2'd2)
                        begin
                            phase_reg <= PH_IDLE;
                            done      <= 1'b1;
                        end
                        else
                        begin
                            axis_reg <= axis_reg + 2'd1;
                            lo_reg   <= '0;
                            hi_reg   <= QW'(1) << CF;
                        end
                    end
                    else
                    begin
                        t_reg     <= TW'({mid, 1'b0}) - TW'(1);
                        phase_reg <= PH_SQ;
                    end
                end
                PH_SQ:
                begin
                    tt_reg    <= (2*TW)'(t_reg) * (2*TW)'(t_reg);
                    phase_reg <= PH_MUL;
                end
                PH_MUL:
                begin
                    prod_reg  <= PW'(tt_reg) * PW'(sum_reg);
                    phase_reg <= PH_CMP;
                end
                PH_CMP:
                begin
                    if (prod_reg <= rhs)
                        lo_reg <= mid;
                    else
                        hi_reg <= mid - QW'(1);
                    phase_reg <= PH_MID;
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    assign o = o_reg;
endmodule

[design/ico_datapath.sv]
// Datapath: triangle stack, work registers, midpoint normalizer, output register.
// Depends on ico_pkg and ico_norm.
module ico_datapath #(
    parameter int COORD_WIDTH = 16,
    parameter int MAX_LEVEL   = 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ico_pkg::ico_cmd_t            cmd,
    output ico_pkg::ico_stat_t           stat,
    input  logic [9*COORD_WIDTH-1:0]     in_tri,
    input  logic [ico_pkg::LEVEL_WIDTH-1:0] target,
    input  logic                         out_take,
    output logic [9*COORD_WIDTH-1:0]     out_tri,
    output logic                         out_last,
    output logic                         out_valid
);
    localparam int DEPTH = 3 * MAX_LEVEL + 1;
    localparam int SPW   = $clog2(DEPTH + 1);
    localparam int TRW   = 9 * COORD_WIDTH;
    localparam int LW    = ico_pkg::LEVEL_WIDTH;

    logic [TRW-1:0] tri_stk [DEPTH];
    logic [LW-1:0]  lev_stk [DEPTH];
    logic [SPW-1:0] sp_reg;
    logic [TRW-1:0] work_reg;
    logic [LW-1:0]  wlev_reg;
    logic [1:0]     mid_sel_reg;
    logic           norm_run_reg;
    logic signed [COORD_WIDTH-1:0] mid_reg [3][3];

    logic signed [COORD_WIDTH-1:0] v [3][3];
    logic signed [COORD_WIDTH-1:0] np [3], nr [3], no [3];
    logic norm_start, norm_done;
    logic [1:0] nsel;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                v[i][k] = work_reg[(3*i+k)*COORD_WIDTH +: COORD_WIDTH];
        // The normalizer samples its operands on start, so select the midpoint about to begin.
        nsel = cmd.norm_start ? 2'd0 : mid_sel_reg + 2'd1;
        for (int k = 0; k < 3; k++)
        begin
            case (nsel)
                2'd0:    begin np[k] = v[1][k]; nr[k] = v[2][k]; end
                2'd1:    begin np[k] = v[2][k]; nr[k] = v[0][k]; end
                default: begin np[k] = v[0][k]; nr[k] = v[1][k]; end
            endcase
        end
    end

    assign norm_start = cmd.norm_start || (norm_run_reg && norm_done && mid_sel_reg != 2'd2);

    ico_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm (
        .clk(clk), .rst_n(rst_n), .start(norm_start),
        .p(np), .r(nr), .done(norm_done), .o(no)
    );

    function automatic logic [TRW-1:0] pack3(
        input logic signed [COORD_WIDTH-1:0] a [3],
        input logic signed [COORD_WIDTH-1:0] b [3],
        input logic signed [COORD_WIDTH-1:0] c [3]);
        logic [TRW-1:0] t;
        for (int k = 0; k < 3; k++)
        begin
            t[k*COORD_WIDTH +: COORD_WIDTH]     = a[k];
            t[(3+k)*COORD_WIDTH +: COORD_WIDTH] = b[k];
            t[(6+k)*COORD_WIDTH +: COORD_WIDTH] = c[k];
        end
        return t;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg       <= '0;
            out_valid    <= 1'b0;
            norm_run_reg <= 1'b0;
            mid_sel_reg  <= 2'd0;
        end
        else
        begin
            if (out_take)
                out_valid <= 1'b0;
            if (cmd.load)
            begin
                tri_stk[0] <= in_tri;
                lev_stk[0] <= '0;
                sp_reg     <= SPW'(1);
            end
            if (cmd.pop)
            begin
                work_reg <= tri_stk[sp_reg - SPW'(1)];
                wlev_reg <= lev_stk[sp_reg - SPW'(1)];
                sp_reg   <= sp_reg - SPW'(1);
            end
            if (cmd.norm_start)
            begin
                norm_run_reg <= 1'b1;
                mid_sel_reg  <= 2'd0;
            end
            if (norm_run_reg && norm_done)
            begin
                mid_reg[mid_sel_reg] <= no;
                if (mid_sel_reg == 2'd2)
                    norm_run_reg <= 1'b0;
                else
                    mid_sel_reg <= mid_sel_reg + 2'd1;
            end
            if (cmd.push_children)
            begin
                // Reverse order so the first child comes off the stack first.
                tri_stk[sp_reg]          <= pack3(mid_reg[0], mid_reg[1], mid_reg[2]);
                tri_stk[sp_reg + SPW'(1)] <= pack3(mid_reg[1], v[0], mid_reg[2]);
                tri_stk[sp_reg + SPW'(2)] <= pack3(v[1], mid_reg[0], mid_reg[2]);
                tri_stk[sp_reg + SPW'(3)] <= pack3(mid_reg[1], mid_reg[0], v[2]);
                for (int j = 0; j < 4; j++)
                    lev_stk[sp_reg + SPW'(j)] <= wlev_reg + LW'(1);
                sp_reg <= sp_reg + SPW'(4);
            end
            if (cmd.emit)
            begin
                out_tri   <= work_reg;
                out_last  <= (sp_reg == '0);
                out_valid <= 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.norm_done   = norm_run_reg && norm_done && mid_sel_reg == 2'd2;
        stat.need_split  = wlev_reg < target;
        stat.stack_empty = (sp_reg == '0);
        stat.out_busy    = out_valid && !out_take;
    end
endmodule

[design/ico_ctrl.sv]
// Controller state machine of the icosphere subdivider.
// Depends on ico_pkg.
module ico_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_req,
    output logic               in_ready,
    input  ico_pkg::ico_stat_t stat,
    output ico_pkg::ico_cmd_t  cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_POP  = 3'd1;
    localparam logic [2:0] ST_DEC  = 3'd2;
    localparam logic [2:0] ST_NORM = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;
    localparam logic [2:0] ST_PUSH = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_req)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                if (stat.need_split)
                begin
                    cmd.norm_start = 1'b1;
                    state_next     = ST_NORM;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_NORM:
            begin
                // The last midpoint is captured on this edge, so the push is done from ST_PUSH once it is registered.
                if (stat.norm_done)
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                cmd.push_children = 1'b1;
                state_next        = ST_POP;
            end
            ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stat.stack_empty ? ST_IDLE : ST_POP;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

[design/icosphere_triangle_subdivider.sv]
// Icosphere triangle subdivider: 4^level leaf triangles per input, depth first.
// Each split normalizes three midpoints by bisection, up to 15 steps per axis, and each leaf
// waits for the output register to be free before it is emitted.
// Level 0 passes each input through as its only leaf; level 3 makes 21 splits and 64 leaves.
// One input at a time; s_axis_tready is high only when the previous input is finished.
// Reset (rst_n, asynchronous, active low) empties the stack and sets the level to 0.
module icosphere_triangle_subdivider #(
    parameter int COORD_WIDTH = 16,
    parameter int MAX_LEVEL   = 3
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz from the lowest bit up
    input  logic [9*COORD_WIDTH-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // out_ax, out_ay, out_az, out_bx, out_by, out_bz, out_cx, out_cy, out_cz
    output logic [9*COORD_WIDTH-1:0] m_axis_tdata,
    output logic m_axis_tlast,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [ico_pkg::LEVEL_WIDTH-1:0] cfg_data
);
    localparam int LW = ico_pkg::LEVEL_WIDTH;
    ico_pkg::ico_cmd_t  cmd;
    ico_pkg::ico_stat_t stat;
    logic [LW-1:0] level_reg, target;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= '0;
        else if (cfg_valid)
            level_reg <= cfg_data;
    end
    assign target = (level_reg > LW'(MAX_LEVEL)) ? LW'(MAX_LEVEL) : level_reg;

    ico_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_req(s_axis_tvalid),
        .in_ready(s_axis_tready), .stat(stat), .cmd(cmd)
    );

    ico_datapath #(.COORD_WIDTH(COORD_WIDTH), .MAX_LEVEL(MAX_LEVEL)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_tri(s_axis_tdata),
        .target(target), .out_take(m_axis_tready), .out_tri(m_axis_tdata),
        .out_last(m_axis_tlast), .out_valid(m_axis_tvalid)
    );
endmodule

[design/ico_checker.sv]
// Port-level checker for the icosphere subdivider, bound to the top level.
// Depends on icosphere_triangle_subdivider_defines.svh.
`include "icosphere_triangle_subdivider_defines.svh"
module ico_checker (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tlast
);
    `ICO_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ICO_ASSERT_IMPL(a_no_out_while_idle, clk, rst_n, s_axis_tready, !m_axis_tvalid || m_axis_tlast)
    `ICO_ASSERT_NEXT(a_out_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

bind icosphere_triangle_subdivider ico_checker u_ico_checker (.*);

[tb/tb.sv]
// Self-checking testbench for icosphere_triangle_subdivider: random and directed triangles
// at every subdivision level, leaf triangles checked against an in-bench predictor.
// Depends on ico_pkg and the subdivider RTL only.
`timescale 1ns / 100ps

module tb;

    localparam int CW = 16;
    localparam int DW = 9 * CW;
    localparam int LVL_MAX = 3;

    typedef logic signed [CW-1:0] coord_t;
    typedef coord_t vert_t [3];

    typedef struct {
        logic [DW-1:0] verts;
        logic          last;
    } leaf_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [DW-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [DW-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_valid;
    logic cfg_ready;
    logic [ico_pkg::LEVEL_WIDTH-1:0] cfg_data;

    logic [DW-1:0] triangle_queue [$];
    leaf_t         leaf_queue [$];
    int            error_count;
    int            burst_left;
    int            gap_left;
    int            stall_phase;
    logic [1:0]    model_level;
    logic          hold_sender;
    logic          run_done;

    icosphere_triangle_subdivider #(
        .COORD_WIDTH(CW),
        .MAX_LEVEL(LVL_MAX)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                   input logic [DW-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic enqueue_triangle(input logic [DW-1:0] d);
        triangle_queue = {triangle_queue, d};
    endtask

    // Midpoint of p and r pushed onto the unit sphere, rounded per axis.
    function automatic vert_t sphere_midpoint(vert_t p, vert_t r);
        vert_t       o;
        longint      s;
        longint unsigned mag [3];
        bit          neg [3];
        longint unsigned sum;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned m;
        longint unsigned t;
        longint unsigned rhs;
        sum = 0;
        for (int k = 0; k < 3; k++)
        begin
            s = longint'(p[k]) + longint'(r[k]);
            neg[k] = s < 0;
            mag[k] = neg[k] ? -s : s;
            sum += mag[k] * mag[k];
        end
        for (int k = 0; k < 3; k++)
        begin
            lo = 0;
            hi = 1 << 14;
            rhs = (4 * mag[k] * mag[k]) << 28;
            if (sum == 0)
            begin
                o[k] = '0;
                continue;
            end
            while (lo < hi)
            begin
                m = (lo + hi + 1) >> 1;
                t = 2 * m - 1;
                if (t * t * sum <= rhs)
                    lo = m;
                else
                    hi = m - 1;
            end
            o[k] = neg[k] ? coord_t'(-longint'(lo)) : coord_t'(lo);
        end
        return o;
    endfunction

    function automatic logic [DW-1:0] pack_triangle(vert_t a, vert_t b, vert_t c);
        logic [DW-1:0] d;
        for (int k = 0; k < 3; k++)
        begin
            d[k*CW +: CW] = a[k];
            d[(3+k)*CW +: CW] = b[k];
            d[(6+k)*CW +: CW] = c[k];
        end
        return d;
    endfunction

    // Depth-first leaves, in the order the block emits them.
    task automatic split_triangle(vert_t a, vert_t b, vert_t c, int depth, bit is_last);
        vert_t ma;
        vert_t mb;
        vert_t mc;
        leaf_t leaf;
        if (depth >= model_level)
        begin
            leaf.verts = pack_triangle(a, b, c);
            leaf.last = is_last;
            leaf_queue = {leaf_queue, leaf};
            return;
        end
        ma = sphere_midpoint(b, c);
        mb = sphere_midpoint(c, a);
        mc = sphere_midpoint(a, b);
        split_triangle(mb, ma, c, depth + 1, 1'b0);
        split_triangle(b, ma, mc, depth + 1, 1'b0);
        split_triangle(mb, a, mc, depth + 1, 1'b0);
        split_triangle(ma, mb, mc, depth + 1, is_last);
    endtask

    function automatic logic [DW-1:0] random_triangle(bit on_sphere);
        logic [DW-1:0] d;
        int sel;
        for (int i = 0; i < 9; i++)
        begin
            d[i*CW +: CW] = coord_t'($urandom);
            if (on_sphere)
                d[i*CW +: CW] = coord_t'($signed($urandom_range(0, 2 * 9459)) - 9459);
        end
        if (on_sphere && $urandom_range(0, 7) == 0)
        begin
            // opposite corners make a zero-length midpoint
            sel = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++)
                d[(((sel + 1) % 3) * 3 + k)*CW +: CW] = -d[(sel * 3 + k)*CW +: CW];
        end
        return d;
    endfunction

    // Driver: bursts with random gaps, held off when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (triangle_queue.size() > 0 && !hold_sender)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= triangle_queue.pop_front();
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 6);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Prediction happens on acceptance so the queue always matches the block.
    always @(posedge clk)
    begin
        vert_t a;
        vert_t b;
        vert_t c;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a[k] = s_axis_tdata[k*CW +: CW];
                b[k] = s_axis_tdata[(3+k)*CW +: CW];
                c[k] = s_axis_tdata[(6+k)*CW +: CW];
            end
            split_triangle(a, b, c, 0, 1'b1);
        end
    end

    // Monitor and receiver stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        leaf_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase % 512 < 128)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (leaf_queue.size() == 0)
                    report_mismatch("unexpected triangle", m_axis_tdata, '0);
                else
                begin
                    want = leaf_queue.pop_front();
                    if (m_axis_tdata !== want.verts)
                        report_mismatch("vertices", m_axis_tdata, want.verts);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("tlast", {{(DW-1){1'b0}}, m_axis_tlast},
                                        {{(DW-1){1'b0}}, want.last});
                end
            end
        end
    end

    task automatic write_level(input logic [1:0] lvl);
        while (triangle_queue.size() > 0 || s_axis_tvalid || leaf_queue.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= lvl;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        model_level = lvl;
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            enqueue_triangle(random_triangle($urandom_range(0, 4) != 0));
    endtask

    initial
    begin
        vert_t px;
        vert_t py;
        vert_t pz;
        vert_t nx;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        hold_sender = 1'b0;
        run_done = 1'b0;
        error_count = 0;
        model_level = 0;
        px = '{16384, 0, 0};
        py = '{0, 16384, 0};
        pz = '{0, 0, 16384};
        nx = '{-16384, 0, 0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Level 0 pass-through, extreme coordinates included.
        enqueue_triangle(pack_triangle(px, py, pz));
        enqueue_triangle({9{16'h7fff}});
        enqueue_triangle({9{16'h8000}});
        enqueue_triangle({{3{16'h8000}}, {3{16'h7fff}}, {3{16'h0000}}});
        queue_random(4);
        write_level(2'd1);
        enqueue_triangle(pack_triangle(px, py, pz));
        enqueue_triangle(pack_triangle(px, nx, pz)); // zero-length midpoint
        enqueue_triangle({9{16'h0000}});
        enqueue_triangle({9{16'h8000}});
        enqueue_triangle({{3{16'h7fff}}, {3{16'h8000}}, {3{16'h7fff}}});
        write_level(2'd3);
        enqueue_triangle(pack_triangle(px, py, pz));
        enqueue_triangle(pack_triangle(nx, py, px));
        write_level(2'd2);
        enqueue_triangle(pack_triangle(pz, nx, py));
        queue_random(2);

        for (int phase = 0; phase < 8; phase++)
        begin
            write_level(phase == 7 ? 2'd3 : 2'($urandom_range(0, 3)));
            queue_random(model_level == 3 ? 8 : 30);
            if (phase == 3)
            begin
                // Pause the sender until the block has drained.
                while (triangle_queue.size() > 20)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (s_axis_tvalid || leaf_queue.size() > 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
        end
        write_level(2'd0);
        queue_random(32);

        while (triangle_queue.size() > 0 || s_axis_tvalid || leaf_queue.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        run_done = 1'b1;
        if (error_count == 0)
            $display("PASS icosphere_triangle_subdivider");
        else
            $display("FAIL icosphere_triangle_subdivider");
        $finish;
    end

    initial
    begin
        #40_000_000;
        if (!run_done)
        begin
            $display("FAIL icosphere_triangle_subdivider");
            $finish;
        end
    end

endmodule

[filelist.f]
+incdir+design
design/ico_pkg.sv
design/ico_norm.sv
design/ico_datapath.sv
design/ico_ctrl.sv
design/icosphere_triangle_subdivider.sv
design/ico_checker.sv
tb/tb.sv
